// File: sv/assert_macros.svh
// Assertion macros used by the checker file of the color converter.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLY(label, clk, rst_n, cond, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
		else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, cond, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
		else $error("assertion failed: next-cycle implication");

`endif

// File: sv/rgb2hsv_pkg.sv
// Types and constants shared by the RGB to HSV pipeline.
`default_nettype none
package rgb2hsv_pkg;

	localparam int ChanW = 8;
	// One quotient bit is produced per division cell.
	localparam int DivSteps = 8;
	localparam int HueStep = 43;
	localparam logic [ChanW-1:0] HueBaseRed = 8'd0;
	localparam logic [ChanW-1:0] HueBaseGreen = 8'd85;
	localparam logic [ChanW-1:0] HueBaseBlue = 8'd171;

	// Partial state of one restoring division.
	typedef struct packed {
		logic [ChanW-1:0] rem;
		logic [ChanW-1:0] dvd_lo;
		logic [ChanW-1:0] dvs;
		logic [ChanW-1:0] quo;
	} div_lane_t;

	typedef struct packed {
		div_lane_t sat;
		div_lane_t hue;
		logic [ChanW-1:0] base;
		logic neg;
		logic [ChanW-1:0] hi;
		logic zero_hi;
		logic zero_span;
	} stage_t;

endpackage
`default_nettype wire

// File: sv/rgb_to_hsv_8bit.sv
// RGB to HSV converter: 8-bit pixel in, 8-bit hue, saturation and value out.
//
// Input channel pixel_valid/pixel_ready carries red, green and blue; output
// channel hsv_valid/hsv_ready carries hue, saturation and brightness.
// A transfer happens on a rising edge where valid and ready are both high.
// One pixel may be transferred every cycle while hsv_ready is high; results come out in order.
// The pipeline is one entry stage (max, min, sector, operands), a row of
// 8 division cells that each resolve one quotient bit of both the
// saturation and the hue divider, and one output stage.
// Every stage holds its own valid flag and loads whenever it is empty or its
// neighbor downstream takes its contents, so while hsv_ready is low the
// pipeline keeps accepting pixels until all 10 stages are full.
// Reset clears every valid flag; no pixel is lost or repeated across stalls.
`default_nettype none
module rgb_to_hsv_8bit (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           pixel_valid,
	output logic                                pixel_ready,
	input  wire logic [rgb2hsv_pkg::ChanW-1:0]  red,
	input  wire logic [rgb2hsv_pkg::ChanW-1:0]  green,
	input  wire logic [rgb2hsv_pkg::ChanW-1:0]  blue,
	output logic                                hsv_valid,
	input  wire logic                           hsv_ready,
	output logic [rgb2hsv_pkg::ChanW-1:0]       hue,
	output logic [rgb2hsv_pkg::ChanW-1:0]       saturation,
	output logic [rgb2hsv_pkg::ChanW-1:0]       brightness
);

	localparam int N = rgb2hsv_pkg::DivSteps;

	logic                vld [0:N];
	logic                rdy [0:N];
	rgb2hsv_pkg::stage_t dat [0:N];

	rgb2hsv_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (pixel_valid),
		.up_ready (pixel_ready),
		.red      (red),
		.green    (green),
		.blue     (blue),
		.dn_valid (vld[0]),
		.dn_ready (rdy[0]),
		.dn_data  (dat[0])
	);

	for (genvar i = 0; i < N; i++) begin : g_cell
		rgb2hsv_div_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.up_valid (vld[i]),
			.up_ready (rdy[i]),
			.up_data  (dat[i]),
			.dn_valid (vld[i+1]),
			.dn_ready (rdy[i+1]),
			.dn_data  (dat[i+1])
		);
	end

	rgb2hsv_out_cell u_out (
		.clk        (clk),
		.arst_n     (arst_n),
		.up_valid   (vld[N]),
		.up_ready   (rdy[N]),
		.up_data    (dat[N]),
		.dn_valid   (hsv_valid),
		.dn_ready   (hsv_ready),
		.hue        (hue),
		.saturation (saturation),
		.brightness (brightness)
	);

endmodule
`default_nettype wire

// File: sv/rgb2hsv_front.sv
// Entry stage: max, min, hue sector and the two division operands.
`default_nettype none
module rgb2hsv_front (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           up_valid,
	output logic                                up_ready,
	input  wire logic [rgb2hsv_pkg::ChanW-1:0]  red,
	input  wire logic [rgb2hsv_pkg::ChanW-1:0]  green,
	input  wire logic [rgb2hsv_pkg::ChanW-1:0]  blue,
	output logic                                dn_valid,
	input  wire logic                           dn_ready,
	output rgb2hsv_pkg::stage_t                 dn_data
);

	localparam int W = rgb2hsv_pkg::ChanW;

	logic valid_q;
	rgb2hsv_pkg::stage_t data_q;
	rgb2hsv_pkg::stage_t nxt;
	logic [W-1:0] hi, lo, span, mag;
	logic [2*W-1:0] sat_dvd, hue_dvd;

	always_comb begin
		hi = (red > green) ? red : green;
		hi = (hi > blue) ? hi : blue;
		lo = (red < green) ? red : green;
		lo = (lo < blue) ? lo : blue;
		span = hi - lo;
		nxt.neg = 1'b0;
		mag = '0;
		nxt.base = rgb2hsv_pkg::HueBaseRed;
		priority if (red == hi) begin
			nxt.base = rgb2hsv_pkg::HueBaseRed;
			nxt.neg = green < blue;
			mag = nxt.neg ? (blue - green) : (green - blue);
		end else if (green == hi) begin
			nxt.base = rgb2hsv_pkg::HueBaseGreen;
			nxt.neg = blue < red;
			mag = nxt.neg ? (red - blue) : (blue - red);
		end else begin
			nxt.base = rgb2hsv_pkg::HueBaseBlue;
			nxt.neg = red < green;
			mag = nxt.neg ? (green - red) : (red - green);
		end
		// 255 * span, written as a shift and a subtract.
		sat_dvd = {span, {W{1'b0}}} - {{W{1'b0}}, span};
		hue_dvd = {{W{1'b0}}, mag} * (2*W)'(rgb2hsv_pkg::HueStep);
		// Both dividends stay below 256 times their divisor, so the high
		// byte is already a valid partial remainder.
		nxt.sat.rem = sat_dvd[2*W-1:W];
		nxt.sat.dvd_lo = sat_dvd[W-1:0];
		nxt.sat.dvs = hi;
		nxt.sat.quo = '0;
		nxt.hue.rem = hue_dvd[2*W-1:W];
		nxt.hue.dvd_lo = hue_dvd[W-1:0];
		nxt.hue.dvs = span;
		nxt.hue.quo = '0;
		nxt.hi = hi;
		nxt.zero_hi = (hi == '0);
		nxt.zero_span = (span == '0);
	end

	assign up_ready = !valid_q || dn_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (up_ready) begin
			valid_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_valid && up_ready) begin
			data_q <= nxt;
		end
	end

	assign dn_valid = valid_q;
	assign dn_data = data_q;

endmodule
`default_nettype wire

// File: sv/rgb2hsv_div_cell.sv
// Division cell: one restoring step for both dividers, then a register.
`default_nettype none
module rgb2hsv_div_cell (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 up_valid,
	output logic                      up_ready,
	input  wire rgb2hsv_pkg::stage_t  up_data,
	output logic                      dn_valid,
	input  wire logic                 dn_ready,
	output rgb2hsv_pkg::stage_t       dn_data
);

	localparam int W = rgb2hsv_pkg::ChanW;

	logic valid_q;
	rgb2hsv_pkg::stage_t data_q;
	rgb2hsv_pkg::stage_t nxt;

	function automatic rgb2hsv_pkg::div_lane_t div_step(rgb2hsv_pkg::div_lane_t l);
		rgb2hsv_pkg::div_lane_t r;
		logic [W:0] trial;
		logic       take;
		trial = {l.rem, l.dvd_lo[W-1]};
		take = trial >= {1'b0, l.dvs};
		r = l;
		r.rem = take ? W'(trial - {1'b0, l.dvs}) : trial[W-1:0];
		r.dvd_lo = {l.dvd_lo[W-2:0], 1'b0};
		r.quo = {l.quo[W-2:0], take};
		return r;
	endfunction

	always_comb begin
		nxt = up_data;
		nxt.sat = div_step(up_data.sat);
		nxt.hue = div_step(up_data.hue);
	end

	assign up_ready = !valid_q || dn_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (up_ready) begin
			valid_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_valid && up_ready) begin
			data_q <= nxt;
		end
	end

	assign dn_valid = valid_q;
	assign dn_data = data_q;

endmodule
`default_nettype wire

// File: sv/rgb2hsv_out_cell.sv
// Output stage: signs the hue offset, adds the sector base, masks gray and black.
`default_nettype none
module rgb2hsv_out_cell (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           up_valid,
	output logic                                up_ready,
	input  wire rgb2hsv_pkg::stage_t            up_data,
	output logic                                dn_valid,
	input  wire logic                           dn_ready,
	output logic [rgb2hsv_pkg::ChanW-1:0]       hue,
	output logic [rgb2hsv_pkg::ChanW-1:0]       saturation,
	output logic [rgb2hsv_pkg::ChanW-1:0]       brightness
);

	localparam int W = rgb2hsv_pkg::ChanW;

	logic valid_q;
	logic [W-1:0] hue_q, sat_q, val_q;
	logic [W-1:0] off, hue_d, sat_d;

	always_comb begin
		off = up_data.neg ? (~up_data.hue.quo + W'(1)) : up_data.hue.quo;
		hue_d = up_data.zero_span ? '0 : (up_data.base + off);
		sat_d = up_data.zero_hi ? '0 : up_data.sat.quo;
	end

	assign up_ready = !valid_q || dn_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (up_ready) begin
			valid_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_valid && up_ready) begin
			hue_q <= hue_d;
			sat_q <= sat_d;
			val_q <= up_data.hi;
		end
	end

	assign dn_valid = valid_q;
	assign hue = hue_q;
	assign saturation = sat_q;
	assign brightness = val_q;

endmodule
`default_nettype wire

// File: sv/rgb2hsv_checker.sv
// Port-level checks for the RGB to HSV converter and their binding.
`default_nettype none
`include "assert_macros.svh"
module rgb2hsv_checker (
	input wire logic                           clk,
	input wire logic                           arst_n,
	input wire logic                           hsv_valid,
	input wire logic                           hsv_ready,
	input wire logic [rgb2hsv_pkg::ChanW-1:0]  hue,
	input wire logic [rgb2hsv_pkg::ChanW-1:0]  saturation,
	input wire logic [rgb2hsv_pkg::ChanW-1:0]  brightness
);

	logic [3*rgb2hsv_pkg::ChanW-1:0] result;

	assign result = {hue, saturation, brightness};

	// A stalled result stays offered and unchanged.
	`ASSERT_NEXT(a_out_hold, clk, arst_n, hsv_valid && !hsv_ready, hsv_valid && $stable(result))
	// Black pixels carry neither hue nor saturation.
	`ASSERT_IMPLY(a_black, clk, arst_n, hsv_valid && (brightness == '0), (saturation | hue) == '0)
	// Gray pixels carry no hue.
	`ASSERT_IMPLY(a_gray, clk, arst_n, hsv_valid && (saturation == '0), hue == '0)

endmodule

bind rgb_to_hsv_8bit rgb2hsv_checker u_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.hsv_valid  (hsv_valid),
	.hsv_ready  (hsv_ready),
	.hue        (hue),
	.saturation (saturation),
	.brightness (brightness)
);
`default_nettype wire
